// File: hdl/bpe_pkg.sv
package bpe_pkg;

  localparam int MAX_PAIRS = 16;
  localparam int WORD_W    = 32;
  localparam int PAIR_W    = 5;
  localparam int LEN_W     = 6;
  localparam int IDX_W     = 5;

  localparam logic [PAIR_W-1:0] PAIR_COUNT_RST = PAIR_W'(1);
  localparam logic [PAIR_W-1:0] PAIR_LIMIT     = PAIR_W'(MAX_PAIRS);

  // Character codes as stored in a word.
  localparam logic OPEN_CH  = 1'b0;
  localparam logic CLOSE_CH = 1'b1;

  // Close characters at every even bit: the string "()()...()".
  localparam logic [WORD_W-1:0] LAST_PATTERN = 32'h5555_5555;

  typedef struct packed {
    logic load;
    logic step;
  } bpe_scan_ctrl_t;

  typedef struct packed {
    logic             last_bit;
    logic             balanced;
    logic             found;
    logic [IDX_W-1:0] tail;
    logic [LEN_W-1:0] opens_at;
  } bpe_scan_stat_t;

  // Ones in the k lowest bits, k from 0 up to the full word width.
  function automatic logic [WORD_W-1:0] low_mask(input logic [LEN_W-1:0] k);
    logic [WORD_W:0] t;
    t = ((WORD_W+1)'(1) << k) - (WORD_W+1)'(1);
    return t[WORD_W-1:0];
  endfunction

endpackage

// File: hdl/balanced_parens_enumerator.sv
// Balanced parenthesis enumerator.
// Each beat on the input channel (in_restart) asks for one string; each beat on the
// output channel returns it in out_sequence_res, character i at bit 2n-1-i with 1
// for a close, and out_is_last flags the final string of the enumeration. A restart,
// the first request after reset, or a request after the last string gives the first
// string. The pair count n is written through cfg_wr_en/cfg_wr_data; the user must
// write it only while the block is idle, which the block itself does not enforce.
// n saturates at 16; n of zero gives the empty string, flagged last. A restart or
// first request goes straight to the finish state, which loads the output register.
// A next request first walks the stored string one character per cycle through a
// single scan unit, then finishes the same way. One request is in flight at a time:
// in_ready is high only while the sequencer is idle. The result sits in an output
// register, so a new request may be taken while the receiver stalls; a finished
// string then waits until that register empties.
// Reset sets n to 1, clears the stored string and drops out_valid.
module balanced_parens_enumerator import bpe_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_restart,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [WORD_W-1:0] out_sequence_res,
  output logic              out_is_last,
  input  logic              cfg_wr_en,
  input  logic [PAIR_W-1:0] cfg_wr_data
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  logic [1:0]        state_r, state_nxt;
  logic [PAIR_W-1:0] pair_count_r;
  logic [WORD_W-1:0] word_r, word_nxt;
  logic              started_r, started_nxt;
  logic              force_first_r, force_first_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [WORD_W-1:0] out_seq_r, out_seq_nxt;
  logic              out_last_r, out_last_nxt;

  logic [PAIR_W-1:0] n_eff;
  logic [LEN_W-1:0]  len;
  logic              in_beat;
  logic              out_free;
  bpe_scan_ctrl_t    scan_ctrl;
  bpe_scan_stat_t    scan_stat;

  logic [LEN_W-1:0]  rem;
  logic [LEN_W-1:0]  ones;
  logic [LEN_W-1:0]  tail_w;
  logic [WORD_W-1:0] succ_word;
  logic [WORD_W-1:0] first_word;
  logic [WORD_W-1:0] last_word;
  logic [WORD_W-1:0] next_word;

  assign n_eff    = (pair_count_r > PAIR_LIMIT) ? PAIR_LIMIT : pair_count_r;
  assign len      = {n_eff, 1'b0};
  assign in_ready = (state_r == ST_IDLE);
  assign in_beat  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  bpe_scan u_scan (
    .clk  (clk),
    .rst_n(rst_n),
    .ctrl (scan_ctrl),
    .word (word_r),
    .len  (len),
    .stat (scan_stat)
  );

  // The chosen open becomes a close; after it come the remaining opens and then closes.
  assign tail_w     = LEN_W'(scan_stat.tail);
  assign rem        = LEN_W'(n_eff) - scan_stat.opens_at;
  assign ones       = tail_w - rem;
  assign succ_word  = (word_r & ~low_mask(tail_w + LEN_W'(1)))
                    | (WORD_W'(1) << scan_stat.tail)
                    | low_mask(ones);
  assign first_word = low_mask(LEN_W'(n_eff));
  assign last_word  = LAST_PATTERN & low_mask(len);
  assign next_word  = (force_first_r || !scan_stat.balanced || !scan_stat.found)
                    ? first_word : succ_word;

  always_comb begin
    state_nxt       = state_r;
    word_nxt        = word_r;
    started_nxt     = started_r;
    force_first_nxt = force_first_r;
    out_valid_nxt   = out_valid_r;
    out_seq_nxt     = out_seq_r;
    out_last_nxt    = out_last_r;
    scan_ctrl.load  = 1'b0;
    scan_ctrl.step  = 1'b0;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      ST_IDLE: begin
        if (in_beat) begin
          if (in_restart || !started_r || (len == '0)) begin
            force_first_nxt = 1'b1;
            state_nxt       = ST_FIN;
          end else begin
            force_first_nxt = 1'b0;
            scan_ctrl.load  = 1'b1;
            state_nxt       = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        scan_ctrl.step = 1'b1;
        if (scan_stat.last_bit) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          word_nxt      = next_word;
          started_nxt   = 1'b1;
          out_valid_nxt = 1'b1;
          out_seq_nxt   = next_word;
          out_last_nxt  = (next_word == last_word);
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      pair_count_r <= PAIR_COUNT_RST;
      word_r       <= '0;
      started_r    <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      word_r      <= word_nxt;
      started_r   <= started_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        pair_count_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    force_first_r <= force_first_nxt;
    out_seq_r     <= out_seq_nxt;
    out_last_r    <= out_last_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_sequence_res = out_seq_r;
  assign out_is_last      = out_last_r;

  // Every balanced string of n pairs holds exactly n closes.
  a_close_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ($countones(out_seq_r) == int'(n_eff)))
    else $error("result does not hold n closes");

  a_beat_starts_work: assert property (@(posedge clk) disable iff (!rst_n)
    in_beat |=> (state_r == ST_SCAN || state_r == ST_FIN))
    else $error("accepted beat did not start work");

  a_scan_continues: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN && !scan_stat.last_bit) |=> (state_r == ST_SCAN))
    else $error("scan left before the last character");

  a_fin_delivers: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN && out_free) |=> (out_valid_r && state_r == ST_IDLE))
    else $error("finished string not placed in the output register");

endmodule

// File: hdl/bpe_scan.sv
module bpe_scan import bpe_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  bpe_scan_ctrl_t      ctrl,
  input  logic [WORD_W-1:0]   word,
  input  logic [LEN_W-1:0]    len,
  output bpe_scan_stat_t      stat
);

  logic [IDX_W-1:0] idx_r,      idx_nxt;
  logic [LEN_W-1:0] depth_r,    depth_nxt;
  logic [LEN_W-1:0] opens_r,    opens_nxt;
  logic             bad_r,      bad_nxt;
  logic             found_r,    found_nxt;
  logic [IDX_W-1:0] tail_r,     tail_nxt;
  logic [LEN_W-1:0] opens_at_r, opens_at_nxt;
  logic [LEN_W-1:0] len_m1;

  assign len_m1 = len - LEN_W'(1);

  always_comb begin
    idx_nxt      = idx_r;
    depth_nxt    = depth_r;
    opens_nxt    = opens_r;
    bad_nxt      = bad_r;
    found_nxt    = found_r;
    tail_nxt     = tail_r;
    opens_at_nxt = opens_at_r;
    if (ctrl.load) begin
      idx_nxt   = len_m1[IDX_W-1:0];
      depth_nxt = '0;
      opens_nxt = '0;
      found_nxt = 1'b0;
      // Any set bit above the string makes the stored word unusable.
      bad_nxt   = (word & ~low_mask(len)) != '0;
    end else if (ctrl.step) begin
      idx_nxt = idx_r - IDX_W'(1);
      if (word[idx_r] == OPEN_CH) begin
        // An open inside a nested group is the latest place that can turn into a close.
        if (depth_r != '0) begin
          found_nxt    = 1'b1;
          tail_nxt     = idx_r;
          opens_at_nxt = opens_r;
        end
        depth_nxt = depth_r + LEN_W'(1);
        opens_nxt = opens_r + LEN_W'(1);
      end else if (depth_r == '0) begin
        bad_nxt = 1'b1;
      end else begin
        depth_nxt = depth_r - LEN_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= '0;
      depth_r <= '0;
      opens_r <= '0;
      bad_r   <= 1'b0;
      found_r <= 1'b0;
    end else begin
      idx_r   <= idx_nxt;
      depth_r <= depth_nxt;
      opens_r <= opens_nxt;
      bad_r   <= bad_nxt;
      found_r <= found_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tail_r     <= tail_nxt;
    opens_at_r <= opens_at_nxt;
  end

  assign stat.last_bit = (idx_r == '0);
  assign stat.balanced = !bad_r && (depth_r == '0);
  assign stat.found    = found_r;
  assign stat.tail     = tail_r;
  assign stat.opens_at = opens_at_r;

endmodule
